// ===== hw/rtl/chs_pkg.sv =====
// shared types and constants of the chained hash set
`timescale 1ns / 1ps

package chs_pkg;

  localparam int unsigned KEY_W = 31;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_DECIDE,
    ST_WALK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic clear_en;
    logic capture;
    logic hash_step;
    logic head_rd;
    logic ins_commit;
    logic set_full;
    logic walk_start;
    logic walk_adv;
    logic set_found;
    logic del_commit;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hash_done;
    op_e  op;
    logic full;
    logic head_valid;
    logic match;
    logic walk_more;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/chs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module chs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/chs_ctrl.sv =====
// request sequencer of the chained hash set
`timescale 1ns / 1ps

module chs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  chs_pkg::stat_t stat_i,
  output chs_pkg::cmd_t  cmd_o
);
  import chs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_HASH;
      ST_HASH:   if (stat_i.hash_done) state_d = ST_HEAD;
      ST_HEAD:   state_d = ST_DECIDE;
      ST_DECIDE: begin
        if ((stat_i.op == OP_SEARCH || stat_i.op == OP_DELETE) && stat_i.head_valid) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_WALK:   if (stat_i.match || !stat_i.walk_more) state_d = ST_RESP;
      ST_RESP:   if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_en = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_HASH: cmd_o.hash_step = 1'b1;
      ST_HEAD: cmd_o.head_rd = 1'b1;
      ST_DECIDE: begin
        unique case (stat_i.op)
          OP_INSERT: begin
            cmd_o.set_full = stat_i.full;
            cmd_o.ins_commit = !stat_i.full;
          end
          OP_SEARCH, OP_DELETE: cmd_o.walk_start = stat_i.head_valid;
          default: ;
        endcase
      end
      ST_WALK: begin
        if (stat_i.match) begin
          cmd_o.set_found = 1'b1;
          cmd_o.del_commit = (stat_i.op == OP_DELETE);
        end else begin
          cmd_o.walk_adv = stat_i.walk_more;
        end
      end
      ST_RESP: cmd_o.resp_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/chs_datapath.sv =====
// bucket hashing, node memories, free stack and result register
`timescale 1ns / 1ps

module chs_datapath #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned POOL_DEPTH  = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               req_type_i,
  input  logic [chs_pkg::KEY_W-1:0] key_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic                     found_o,
  output logic                     status_o,
  input  chs_pkg::cmd_t            cmd_i,
  output chs_pkg::stat_t           stat_o
);
  import chs_pkg::*;

  localparam int unsigned BW = $clog2(NUM_BUCKETS);
  localparam int unsigned AW = $clog2(POOL_DEPTH);
  localparam int unsigned PW = $clog2(POOL_DEPTH + 1);
  localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);
  localparam logic [BW:0] NB = (BW + 1)'(NUM_BUCKETS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(NUM_BUCKETS));

  op_e                 op_q;
  logic [KEY_W-1:0]    key_q;
  logic                hash_ph_q;
  logic [KEY_W-1:0]    quot_q;
  logic [BW-1:0]       rem_q;
  logic [BW-1:0]       clr_cnt_q;
  logic [PW-1:0]       cur_q, prev_q, steps_q, sp_q, fresh_q;
  logic                found_q, full_q;
  logic                out_valid_q, out_found_q, out_status_q;

  logic [KEY_W+31:0]   prod;
  logic [2*BW+1:0]     qn;
  logic [BW:0]         rem_sh;
  logic [BW:0]         rem_red;
  logic [PW-1:0]       head, nxt, key_sel_n;
  logic [KEY_W-1:0]    node_key_rd;
  logic [PW-1:0]       stack_rd;
  logic [PW:0]         steps_inc;

  logic                bk_we;
  logic [BW-1:0]       bk_waddr;
  logic [PW-1:0]       bk_wdata;
  logic                nx_we;
  logic [AW-1:0]       nx_waddr;
  logic [PW-1:0]       nx_wdata;
  logic [AW-1:0]       node_raddr;

  // bucket index: quotient by reciprocal multiply (low by at most one),
  // then the remainder from the low bits and one compare and subtract
  assign prod    = key_q * RECIP;
  assign qn      = quot_q[BW:0] * NB;
  assign rem_sh  = key_q[BW:0] - qn[BW:0];
  assign rem_red = (rem_sh >= NB) ? (rem_sh - NB) : rem_sh;

  assign key_sel_n = (sp_q != '0) ? stack_rd : fresh_q;
  assign steps_inc = {1'b0, steps_q} + (PW + 1)'(1);

  always_comb begin
    bk_we = 1'b0;
    bk_waddr = rem_q;
    bk_wdata = NIL;
    if (cmd_i.clear_en) begin
      bk_we = 1'b1;
      bk_waddr = clr_cnt_q;
    end else if (cmd_i.ins_commit) begin
      bk_we = 1'b1;
      bk_wdata = key_sel_n;
    end else if (cmd_i.del_commit && prev_q == NIL) begin
      bk_we = 1'b1;
      bk_wdata = nxt;
    end
  end

  always_comb begin
    nx_we = 1'b0;
    nx_waddr = key_sel_n[AW-1:0];
    nx_wdata = head;
    if (cmd_i.ins_commit) begin
      nx_we = 1'b1;
    end else if (cmd_i.del_commit && prev_q != NIL) begin
      nx_we = 1'b1;
      nx_waddr = prev_q[AW-1:0];
      nx_wdata = nxt;
    end
  end

  assign node_raddr = cmd_i.walk_start ? head[AW-1:0] : nxt[AW-1:0];

  chs_ram #(.WIDTH(PW), .DEPTH(NUM_BUCKETS)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bk_we),
    .waddr_i (bk_waddr),
    .wdata_i (bk_wdata),
    .raddr_i (rem_q),
    .rdata_o (head)
  );

  chs_ram #(.WIDTH(KEY_W), .DEPTH(POOL_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_commit),
    .waddr_i (key_sel_n[AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (node_raddr),
    .rdata_o (node_key_rd)
  );

  chs_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (node_raddr),
    .rdata_o (nxt)
  );

  chs_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.del_commit),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (cur_q),
    .raddr_i (AW'(sp_q - PW'(1))),
    .rdata_o (stack_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_e'(req_type_i);
      key_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_ph_q <= 1'b0;
      quot_q <= '0;
      rem_q <= '0;
      clr_cnt_q <= '0;
      cur_q <= NIL;
      prev_q <= NIL;
      steps_q <= '0;
      sp_q <= '0;
      fresh_q <= '0;
      found_q <= 1'b0;
      full_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_status_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) clr_cnt_q <= clr_cnt_q + BW'(1);
      if (cmd_i.capture) begin
        hash_ph_q <= 1'b0;
        rem_q <= '0;
        found_q <= 1'b0;
        full_q <= 1'b0;
      end
      if (cmd_i.hash_step) begin
        if (!hash_ph_q) begin
          quot_q <= prod[KEY_W+31:32];
          hash_ph_q <= 1'b1;
        end else begin
          rem_q <= rem_red[BW-1:0];
        end
      end
      if (cmd_i.ins_commit) begin
        if (sp_q != '0) sp_q <= sp_q - PW'(1);
        else fresh_q <= fresh_q + PW'(1);
      end
      if (cmd_i.del_commit) sp_q <= sp_q + PW'(1);
      if (cmd_i.set_full) full_q <= 1'b1;
      if (cmd_i.set_found) found_q <= 1'b1;
      if (cmd_i.walk_start) begin
        cur_q <= head;
        prev_q <= NIL;
        steps_q <= '0;
      end
      if (cmd_i.walk_adv) begin
        prev_q <= cur_q;
        cur_q <= nxt;
        steps_q <= steps_inc[PW-1:0];
      end
      if (cmd_i.resp_load) begin
        out_valid_q <= 1'b1;
        out_found_q <= found_q;
        out_status_q <= full_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.clear_done = (clr_cnt_q == BW'(NUM_BUCKETS - 1));
  assign stat_o.hash_done  = hash_ph_q;
  assign stat_o.op         = op_q;
  assign stat_o.full       = (fresh_q == NIL) && (sp_q == '0);
  assign stat_o.head_valid = (head < NIL);
  assign stat_o.match      = (node_key_rd == key_q);
  assign stat_o.walk_more  = (nxt < NIL) && (steps_inc < (PW + 1)'(POOL_DEPTH));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign found_o = out_found_q;
  assign status_o = out_status_q;

endmodule

// ===== hw/rtl/chained_hash_set_core.sv =====
// top level of the chained hash set core
// steps: bucket hashing, head read, decide, then a walk of the chain
//   (at most POOL_DEPTH nodes walked), then the response to the output
// only one item is in work at a time:
// the next item is taken once the previous result sits in the output register
// reset: asynchronous, active low; afterwards a clearing pass over all
//   NUM_BUCKETS entries empties the bucket table before the first item is taken
`timescale 1ns / 1ps

module chained_hash_set_core #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned POOL_DEPTH  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [30:0] key, [31] zero pad
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // [0] found, [1] status, [7:2] zero pad
);
  import chs_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  found, status;

  // sequencer: clearing pass, hashing, head read, decide, chain walk, response
  chs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memories, free node stack and output register
  chs_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .POOL_DEPTH  (POOL_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (s_axis_tuser_i),
    .key_i       (s_axis_tdata_i[KEY_W-1:0]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .found_o     (found),
    .status_o    (status),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // result item packing
  assign m_axis_tdata_o = {6'b0, status, found};

endmodule

// ===== hw/rtl/chs_checker.sv =====
// port level assertions of the chained hash set core and their bind
`timescale 1ns / 1ps

module chs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after accept");

  // hashing keeps a result from appearing right after accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result too early");

  // a refused insert never reports found
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> !m_axis_tdata_o[0])
    else $error("full status with found");

endmodule

bind chained_hash_set_core chs_checker u_chs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
